FILE: rtl/core/lcg64_pkg.sv
// lcg64_pkg: types, constants and helpers for the 64-bit LCG range generator.
// No dependencies; used by lcg64_random_in_range.
`default_nettype none

package lcg64_pkg;

    // Generator constants: state = state * LCG_MUL + LCG_ADD (mod 2^64)
    localparam logic [63:0] LCG_MUL = 64'd2862933555777941757;
    localparam logic [63:0] LCG_ADD = 64'd696969696969;
    localparam logic [63:0] TOP_BIT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MASK_W64 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MASK_W32 = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] MASK_W8 = 64'h0000_0000_0000_00FF;

    // Opcode map
    localparam logic [3:0] OP_U64 = 4'd0;
    localparam logic [3:0] OP_U32 = 4'd1;
    localparam logic [3:0] OP_U8 = 4'd2;
    localparam logic [3:0] OP_S64 = 4'd3;
    localparam logic [3:0] OP_S32 = 4'd4;
    localparam logic [3:0] OP_S8 = 4'd5;
    localparam logic [3:0] OP_RANGED_FIRST = 4'd6;
    localparam logic [3:0] OP_LAST = 4'd11;

    localparam int OPCODE_W = 4;
    localparam int DIV_CNT_W = 6;

    typedef enum logic [1:0] {
        W64,
        W32,
        W8
    } t_width;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_EVAL,
        S_DIV,
        S_FIN,
        S_OUT
    } t_fsm;

    // Zero- or sign-extend the low bits of x at the given width.
    function automatic logic [63:0] ext(input logic [63:0] x, input t_width w,
                                        input logic sgn);
        logic [63:0] y;
        unique case (w)
            W64: y = x;
            W32: y = {{32{sgn & x[31]}}, x[31:0]};
            W8: y = {{56{sgn & x[7]}}, x[7:0]};
            default: y = x;
        endcase
        return y;
    endfunction

    function automatic logic [63:0] width_mask(input t_width w);
        logic [63:0] m;
        unique case (w)
            W64: m = MASK_W64;
            W32: m = MASK_W32;
            W8: m = MASK_W8;
            default: m = MASK_W64;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lcg64_random_in_range.sv
// lcg64_random_in_range: 64-bit LCG with optional range reduction.
// Depends on lcg64_pkg.
//
// Each request word takes its opcode on s_tuser (u64/u32/u8/s64/s32/s8, plain
// or ranged) and its bounds on s_tdata. The 64-bit generator state steps as
// state*2862933555777941757 + 696969696969 mod 2^64; the step is done on one
// shared 32x32 multiplier in S_MUL0..S_MUL3 (three partial products, then the
// final add). The top bits of the new state form the raw value. A ranged
// request reduces the raw value by the span (high-low+1) with a radix-2
// restoring remainder unit, one bit per cycle in S_DIV; a span that covers the
// full width skips it. After the step a ranged word goes through S_EVAL, S_DIV
// and S_FIN to S_OUT, a plain word from S_EVAL to S_OUT, and an empty range
// (high not above low) straight to S_OUT with no state step. Opcodes 12..15
// are dropped with no result. The block takes one word at a time: s_tready is
// high only when idle. A seed write on the cfg channel loads the state; it is
// always ready and must only be used while the block is idle.
`default_nettype none

module lcg64_random_in_range (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // seed write channel
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [63:0]   i_cfg_data,
    // request stream
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic [127:0]  i_s_tdata,   // [63:0] low_bound, [127:64] high_bound
    input  wire logic [3:0]    i_s_tuser,   // [3:0] opcode
    // result stream
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic [63:0]        o_m_tdata,   // [63:0] value
    output logic [0:0]         o_m_tuser    // [0] empty_range
);

    // control
    lcg64_pkg::t_fsm   r_fsm, n_fsm;
    logic [lcg64_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;

    // generator state and multiply datapath
    logic [63:0] r_gen, n_gen;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_prod, n_prod;

    // request context
    lcg64_pkg::t_width r_wsel, n_wsel;
    logic        r_sgn, n_sgn;
    logic        r_ranged, n_ranged;
    logic [63:0] r_lo, n_lo;
    logic [63:0] r_diff, n_diff;

    // remainder unit
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_dvd, n_dvd;
    logic [63:0] r_span, n_span;
    logic        r_neg, n_neg;

    // result register
    logic [63:0] r_value, n_value;
    logic        r_empty, n_empty;

    // decode / scratch
    logic [lcg64_pkg::OPCODE_W-1:0] op, kind;
    logic        op_ranged;
    lcg64_pkg::t_width dec_w;
    logic        dec_sgn;
    logic [63:0] in_lo, in_hi;
    logic        is_empty;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [63:0] raw, mag;
    logic [64:0] trial;
    logic        fits;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_fsm == lcg64_pkg::S_IDLE);
    assign o_m_tvalid  = (r_fsm == lcg64_pkg::S_OUT);
    assign o_m_tdata   = r_value;
    assign o_m_tuser   = r_empty;

    // opcode decode
    always_comb begin
        op        = i_s_tuser;
        op_ranged = (op >= lcg64_pkg::OP_RANGED_FIRST);
        kind      = op_ranged ? (op - lcg64_pkg::OP_RANGED_FIRST) : op;
        dec_sgn   = (kind >= lcg64_pkg::OP_S64);
        priority if (kind == lcg64_pkg::OP_U64 || kind == lcg64_pkg::OP_S64) begin
            dec_w = lcg64_pkg::W64;
        end else if (kind == lcg64_pkg::OP_U32 || kind == lcg64_pkg::OP_S32) begin
            dec_w = lcg64_pkg::W32;
        end else begin
            dec_w = lcg64_pkg::W8;
        end
        in_lo = lcg64_pkg::ext(i_s_tdata[63:0], dec_w, dec_sgn);
        in_hi = lcg64_pkg::ext(i_s_tdata[127:64], dec_w, dec_sgn);
        // extended bounds keep their order; signed compare by flipping the top bit
        if (dec_sgn) begin
            is_empty = ((in_hi ^ lcg64_pkg::TOP_BIT) <= (in_lo ^ lcg64_pkg::TOP_BIT));
        end else begin
            is_empty = (in_hi <= in_lo);
        end
    end

    // shared 32x32 multiplier: lo*lo, hi*lo(M), lo*hi(M)
    always_comb begin
        mul_a = (r_fsm == lcg64_pkg::S_MUL1) ? r_gen[63:32] : r_gen[31:0];
        mul_b = (r_fsm == lcg64_pkg::S_MUL2) ? lcg64_pkg::LCG_MUL[63:32]
                                             : lcg64_pkg::LCG_MUL[31:0];
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    // raw value: top bits of the new state, extended
    always_comb begin
        unique case (r_wsel)
            lcg64_pkg::W64: raw = r_gen;
            lcg64_pkg::W32: raw = {32'd0, r_gen[63:32]};
            lcg64_pkg::W8: raw = {56'd0, r_gen[63:56]};
            default: raw = r_gen;
        endcase
        raw = lcg64_pkg::ext(raw, r_wsel, r_sgn);
        mag = (r_sgn && raw[63]) ? (64'd0 - raw) : raw;
    end

    // one restoring remainder step
    always_comb begin
        trial = {r_rem, r_dvd[63]};
        fits  = (trial >= {1'b0, r_span});
    end

    // next state and datapath
    always_comb begin
        n_fsm    = r_fsm;
        n_cnt    = r_cnt;
        n_gen    = r_gen;
        n_acc    = r_acc;
        n_prod   = r_prod;
        n_wsel   = r_wsel;
        n_sgn    = r_sgn;
        n_ranged = r_ranged;
        n_lo     = r_lo;
        n_diff   = r_diff;
        n_rem    = r_rem;
        n_dvd    = r_dvd;
        n_span   = r_span;
        n_neg    = r_neg;
        n_value  = r_value;
        n_empty  = r_empty;

        if (i_cfg_valid) begin
            n_gen = i_cfg_data;
        end

        unique case (r_fsm)
            lcg64_pkg::S_IDLE: begin
                if (i_s_tvalid && op <= lcg64_pkg::OP_LAST) begin
                    n_wsel   = dec_w;
                    n_sgn    = dec_sgn;
                    n_ranged = op_ranged;
                    n_lo     = in_lo;
                    n_diff   = in_hi - in_lo;
                    if (op_ranged && is_empty) begin
                        n_value = 64'd0;
                        n_empty = 1'b1;
                        n_fsm   = lcg64_pkg::S_OUT;
                    end else begin
                        n_fsm = lcg64_pkg::S_MUL0;
                    end
                end
            end
            lcg64_pkg::S_MUL0: begin
                n_prod = mul_p;
                n_fsm  = lcg64_pkg::S_MUL1;
            end
            lcg64_pkg::S_MUL1: begin
                n_acc  = r_prod;
                n_prod = mul_p;
                n_fsm  = lcg64_pkg::S_MUL2;
            end
            lcg64_pkg::S_MUL2: begin
                n_acc  = r_acc + {r_prod[31:0], 32'd0};
                n_prod = mul_p;
                n_fsm  = lcg64_pkg::S_MUL3;
            end
            lcg64_pkg::S_MUL3: begin
                n_gen = r_acc + {r_prod[31:0], 32'd0} + lcg64_pkg::LCG_ADD;
                n_fsm = lcg64_pkg::S_EVAL;
            end
            lcg64_pkg::S_EVAL: begin
                n_empty = 1'b0;
                if (!r_ranged) begin
                    n_value = raw;
                    n_fsm   = lcg64_pkg::S_OUT;
                end else if (r_diff == lcg64_pkg::width_mask(r_wsel)) begin
                    // span covers the full width: no reduction
                    n_value = lcg64_pkg::ext(r_lo + raw, r_wsel, r_sgn);
                    n_fsm   = lcg64_pkg::S_OUT;
                end else begin
                    n_rem  = 64'd0;
                    n_dvd  = mag;
                    n_span = r_diff + 64'd1;
                    n_neg  = r_sgn & raw[63];
                    n_cnt  = '1;
                    n_fsm  = lcg64_pkg::S_DIV;
                end
            end
            lcg64_pkg::S_DIV: begin
                n_rem = fits ? 64'(trial - {1'b0, r_span}) : trial[63:0];
                n_dvd = {r_dvd[62:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_fsm = lcg64_pkg::S_FIN;
                end
            end
            lcg64_pkg::S_FIN: begin
                // remainder takes the sign of the raw value
                n_value = lcg64_pkg::ext(r_neg ? (r_lo - r_rem) : (r_lo + r_rem),
                                         r_wsel, r_sgn);
                n_fsm   = lcg64_pkg::S_OUT;
            end
            lcg64_pkg::S_OUT: begin
                if (i_m_tready) begin
                    n_fsm = lcg64_pkg::S_IDLE;
                end
            end
            default: n_fsm = lcg64_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= lcg64_pkg::S_IDLE;
            r_gen <= 64'd0;
        end else begin
            r_fsm <= n_fsm;
            r_gen <= n_gen;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_acc    <= n_acc;
        r_prod   <= n_prod;
        r_wsel   <= n_wsel;
        r_sgn    <= n_sgn;
        r_ranged <= n_ranged;
        r_lo     <= n_lo;
        r_diff   <= n_diff;
        r_rem    <= n_rem;
        r_dvd    <= n_dvd;
        r_span   <= n_span;
        r_neg    <= n_neg;
        r_value  <= n_value;
        r_empty  <= n_empty;
    end

endmodule

`default_nettype wire

FILE: tb/tb.sv
// tb: self-checking testbench for lcg64_random_in_range.
// Depends on lcg64_pkg and the lcg64_random_in_range RTL; uses an in-bench
// LCG predictor and checks every result word against it.
`timescale 1ns / 100ps

module tb;

    localparam int NUM_RAND = 600;   // defined requests in the random part
    localparam int NUM_PHASES = 5;
    localparam int HOLD_CYCLES = 300;  // long result-side stall
    localparam int DRAIN_CYCLES = 100;  // longer than one ranged request
    localparam int STALL_LIMIT = 4000;

    // ranged opcodes: plain code offset into the ranged block
    localparam logic [3:0] OP_RU64 = lcg64_pkg::OP_RANGED_FIRST + lcg64_pkg::OP_U64;
    localparam logic [3:0] OP_RU32 = lcg64_pkg::OP_RANGED_FIRST + lcg64_pkg::OP_U32;
    localparam logic [3:0] OP_RU8 = lcg64_pkg::OP_RANGED_FIRST + lcg64_pkg::OP_U8;
    localparam logic [3:0] OP_RS64 = lcg64_pkg::OP_RANGED_FIRST + lcg64_pkg::OP_S64;
    localparam logic [3:0] OP_RS32 = lcg64_pkg::OP_RANGED_FIRST + lcg64_pkg::OP_S32;
    localparam logic [3:0] OP_RS8 = lcg64_pkg::OP_RANGED_FIRST + lcg64_pkg::OP_S8;
    localparam logic [3:0] OP_UNDEF = lcg64_pkg::OP_LAST + 4'd1;   // 12..15 are dropped

    typedef struct {
        logic [3:0]  op;
        logic [63:0] lo;
        logic [63:0] hi;
    } t_req;

    typedef struct {
        logic [63:0] value;
        logic        empty;
    } t_draw;

    logic          i_clk;
    logic          i_rst_n = 1'b0;
    logic          cfg_valid = 1'b0;
    logic [63:0]   cfg_data = '0;
    logic          s_tvalid = 1'b0;
    logic [127:0]  s_tdata = '0;    // [63:0] low_bound, [127:64] high_bound
    logic [3:0]    s_tuser = '0;    // [3:0] opcode
    logic          m_tready = 1'b0;
    wire           cfg_ready;
    wire           s_tready;
    wire           m_tvalid;
    wire  [63:0]   m_tdata;         // [63:0] value
    wire  [0:0]    m_tuser;         // [0] empty_range

    t_req          request_q[$];    // words waiting to be offered
    t_draw         draw_q[$];       // expected result words, oldest first
    logic [63:0]   gen_state = '0;  // predictor copy of the generator state
    int            err_cnt = 0;
    int            idle_pct = 19;   // percent of cycles each side idles
    int            hold_req = 0;    // bump to request one long sink stall
    int            hold_seen = 0;
    int            hold_left = 0;
    int            stall_cnt = 0;

    lcg64_random_in_range u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Keep the low bits of x for width w, zero- or sign-extended to 64.
    function automatic logic [63:0] fit_width(input logic [63:0] x,
                                              input lcg64_pkg::t_width w,
                                              input logic sgn);
        logic [63:0] y;
        case (w)
            lcg64_pkg::W32: y = sgn ? {{32{x[31]}}, x[31:0]} : {32'd0, x[31:0]};
            lcg64_pkg::W8: y = sgn ? {{56{x[7]}}, x[7:0]} : {56'd0, x[7:0]};
            default: y = x;
        endcase
        return y;
    endfunction

    // Predict one request; steps gen_state when the block would.
    // Returns 0 for opcodes that produce no result word.
    function automatic bit lcg_draw(input logic [3:0] op, input logic [63:0] lo_in,
                                    input logic [63:0] hi_in, output t_draw r);
        logic              ranged;
        logic [3:0]        kind;
        lcg64_pkg::t_width w;
        logic              sgn;
        logic [63:0]       lo, hi, raw, diff, span, rem, mask;
        int                shamt;

        r.value = '0;
        r.empty = 1'b0;
        if (op > lcg64_pkg::OP_LAST)
            return 0;
        ranged = (op >= lcg64_pkg::OP_RANGED_FIRST);
        kind = ranged ? op - lcg64_pkg::OP_RANGED_FIRST : op;
        sgn = (kind >= lcg64_pkg::OP_S64);
        case (kind)
            lcg64_pkg::OP_U64, lcg64_pkg::OP_S64: begin
                w = lcg64_pkg::W64; shamt = 0; mask = lcg64_pkg::MASK_W64;
            end
            lcg64_pkg::OP_U32, lcg64_pkg::OP_S32: begin
                w = lcg64_pkg::W32; shamt = 32; mask = lcg64_pkg::MASK_W32;
            end
            default: begin
                w = lcg64_pkg::W8; shamt = 56; mask = lcg64_pkg::MASK_W8;
            end
        endcase

        if (ranged) begin
            lo = fit_width(lo_in, w, sgn);
            hi = fit_width(hi_in, w, sgn);
            // empty range: no state step, value 0
            if (sgn ? ($signed(hi) <= $signed(lo)) : (hi <= lo)) begin
                r.empty = 1'b1;
                return 1;
            end
        end

        gen_state = gen_state * lcg64_pkg::LCG_MUL + lcg64_pkg::LCG_ADD;
        raw = fit_width(gen_state >> shamt, w, sgn);
        if (!ranged) begin
            r.value = raw;
            return 1;
        end

        diff = hi - lo;
        if (diff == mask) begin
            rem = raw;                      // span is 2^width: no reduction
        end else begin
            span = diff + 64'd1;
            if (sgn && raw[63])
                rem = 64'd0 - ((64'd0 - raw) % span);   // truncating: keeps sign
            else
                rem = raw % span;
        end
        r.value = fit_width(lo + rem, w, sgn);
        return 1;
    endfunction

    // Request driver: next word once the current one is taken.
    always @(posedge i_clk) begin
        t_req q;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (request_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                q = request_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {q.hi, q.lo};
                s_tuser <= q.op;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result sink: random backpressure plus one long stall on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Predictor hook: seed loads and accepted requests.
    always @(posedge i_clk) begin
        t_draw r;
        if (i_rst_n) begin
            if (cfg_valid && cfg_ready)
                gen_state = cfg_data;
            if (s_tvalid && s_tready) begin
                if (lcg_draw(s_tuser, s_tdata[63:0], s_tdata[127:64], r))
                    draw_q.push_back(r);
            end
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_draw want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (draw_q.size() == 0) begin
                $error("unexpected result word: value %h empty_range %b", m_tdata, m_tuser);
                err_cnt++;
            end else begin
                want = draw_q.pop_front();
                if (m_tdata !== want.value) begin
                    $error("value: expected %h, got %h", want.value, m_tdata);
                    err_cnt++;
                end
                if (m_tuser[0] !== want.empty) begin
                    $error("empty_range: expected %b, got %b", want.empty, m_tuser[0]);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog: cycles with no word moving on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic push_req(input logic [3:0] op, input logic [63:0] lo,
                            input logic [63:0] hi);
        t_req q;
        q.op = op;
        q.lo = lo;
        q.hi = hi;
        request_q.push_back(q);
    endtask

    // One random request; returns 1 when its opcode is defined.
    task automatic push_random(output bit defined);
        int          pick;
        logic [3:0]  op;
        logic [63:0] lo, hi;

        pick = $urandom_range(99);
        if (pick < 4)
            op = 4'($urandom_range(OP_UNDEF, 15));
        else if (pick < 40)
            op = 4'($urandom_range(lcg64_pkg::OP_U64, lcg64_pkg::OP_S8));
        else
            op = 4'($urandom_range(OP_RU64, lcg64_pkg::OP_LAST));

        case ($urandom_range(2))
            0: begin                        // unordered: about half are empty
                lo = rand64();
                hi = rand64();
            end
            1: begin                        // narrow span above a random base
                lo = rand64();
                hi = lo + 64'($urandom_range(1, 1000));
            end
            default: begin                  // straddles zero, random upper junk
                lo = 64'd0 - 64'($urandom_range(0, 60));
                hi = 64'($urandom_range(1, 60));
                if ($urandom_range(1)) begin
                    lo = lo ^ {$urandom, 32'd0};
                    hi = hi ^ {$urandom, 32'd0};
                end
            end
        endcase
        push_req(op, lo, hi);
        defined = (op <= lcg64_pkg::OP_LAST);
    endtask

    // Block until every queued word is offered and every result is back,
    // then let the core settle (dropped opcodes leave nothing to wait on).
    task automatic wait_drain();
        while (request_q.size() != 0 || s_tvalid || draw_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [63:0] s);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= s;
        @(posedge i_clk);
        while (!cfg_ready)
            @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [63:0] seeds[NUM_PHASES];
        bit          defined;
        int          ndef;

        seeds[0] = lcg64_pkg::MASK_W64;
        seeds[1] = 64'd1;
        seeds[2] = rand64();
        seeds[3] = lcg64_pkg::TOP_BIT;
        seeds[4] = rand64();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, run from the reset state (seed 0).
        push_req(lcg64_pkg::OP_U64, '0, '0);
        push_req(lcg64_pkg::OP_U32, '0, '0);
        push_req(lcg64_pkg::OP_U8, '0, '0);
        push_req(lcg64_pkg::OP_S64, '0, '0);
        push_req(lcg64_pkg::OP_S32, '0, '0);
        push_req(lcg64_pkg::OP_S8, '0, '0);
        // full-width spans: raw value passes unreduced
        push_req(OP_RU64, 64'd0, lcg64_pkg::MASK_W64);
        push_req(OP_RS64, lcg64_pkg::TOP_BIT, ~lcg64_pkg::TOP_BIT);
        push_req(OP_RU32, 64'hDEAD_BEEF_0000_0000, 64'h1234_5678_FFFF_FFFF);
        push_req(OP_RS32, 64'h0000_0000_8000_0000, 64'h0000_0000_7FFF_FFFF);
        push_req(OP_RU8, 64'hFFFF_FFFF_FFFF_FF00, 64'h0000_0000_0000_00FF);
        push_req(OP_RS8, 64'h80, 64'h7F);
        // empty ranges: equal bounds, reversed bounds, signed order
        push_req(OP_RU64, 64'd77, 64'd77);
        push_req(OP_RU32, 64'd9, 64'd3);
        push_req(OP_RS8, 64'h7F, 64'h80);
        push_req(OP_RS64, 64'd5, 64'd0 - 64'd5);
        // same bit patterns read unsigned: not empty
        push_req(OP_RU8, 64'h7F, 64'h80);
        // small spans, negative windows, signed remainder of negative raw
        push_req(OP_RU64, 64'd5, 64'd6);
        push_req(OP_RS32, 64'd0 - 64'd10, 64'd0 - 64'd3);
        push_req(OP_RS64, 64'd0 - 64'd1000, 64'd1000);
        push_req(OP_RS8, 64'd0 - 64'd3, 64'd3);
        push_req(OP_RU64, lcg64_pkg::MASK_W64 - 64'd1, lcg64_pkg::MASK_W64);
        // undefined opcodes: no result, no state step
        push_req(OP_UNDEF, rand64(), rand64());
        push_req(4'd15, rand64(), rand64());
        push_req(lcg64_pkg::OP_U64, '0, '0);
        wait_drain();

        // Random part, one seed per phase.
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_seed(seeds[p]);
            if (p == 3)
                idle_pct <= 0;              // stretch with no idling on either side
            ndef = 0;
            while (ndef < NUM_RAND / NUM_PHASES) begin
                push_random(defined);
                if (defined)
                    ndef++;
            end
            if (p == 1)
                hold_req <= hold_req + 1;   // sink stalls while words keep coming
            wait_drain();
            idle_pct <= 19;
        end

        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
